[src/pde_pkg.sv]
package pde_pkg;

  localparam int WORD_W = 32;
  localparam int ITER_W = 5;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [1:0]        status_t;
  typedef logic [2:0]        op_t;

  // expression characters
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;

  // sticky status codes
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_UNDERFLOW = 2'd1;
  localparam status_t ST_DIVZERO   = 2'd2;
  localparam status_t ST_OVERFLOW  = 2'd3;

  // operator classes
  localparam op_t OP_MUL   = 3'd0;
  localparam op_t OP_DIV   = 3'd1;
  localparam op_t OP_ADD   = 3'd2;
  localparam op_t OP_SUB   = 3'd3;
  localparam op_t OP_OTHER = 3'd4;

  function automatic logic is_digit(input logic [7:0] sym);
    return sym inside {[CH_ZERO:CH_NINE]};
  endfunction

  function automatic op_t decode_op(input logic [7:0] sym);
    op_t op;
    case (sym)
      CH_STAR:  op = OP_MUL;
      CH_SLASH: op = OP_DIV;
      CH_PLUS:  op = OP_ADD;
      CH_MINUS: op = OP_SUB;
      default:  op = OP_OTHER;
    endcase
    return op;
  endfunction

endpackage

[src/postfix_digit_evaluator.sv]
// channel | dir | beat fields (tdata / tuser / tlast)
// --------+-----+----------------------------------------------------
// in_     | in  | tdata[7:0] symbol, tlast is_final
// out_    | out | tdata[31:0] value (signed), tuser[1:0] status
//
// per beat: a non-final digit is pushed from idle; + and - pass through the
// add/subtract state; other operators and divide by zero go straight to the push; * and /
// iterate through the shared 33-bit adder/subtractor (shift-add multiply,
// restoring divide, then sign fix); a final beat then hands the result to the
// output register, waiting while that register still holds an untaken beat
// rst_n is synchronous, active low; the operand stack needs no clearing pass
// in_tready is high only while the sequencer is idle
module postfix_digit_evaluator #(
  parameter int STACK_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] symbol
  input  logic        in_tlast,   // is_final
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] value
  output logic [1:0]  out_tuser   // [1:0] status
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);
  localparam logic [CW-1:0] TWO_C   = CW'(2);

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_OPER   = 3'd1;
  localparam logic [2:0] S_ADDSUB = 3'd2;
  localparam logic [2:0] S_MUL    = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;
  localparam logic [2:0] S_NEG    = 3'd5;
  localparam logic [2:0] S_PUSH   = 3'd6;
  localparam logic [2:0] S_EMIT   = 3'd7;

  logic [2:0]              state_r, state_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  pde_pkg::word_t          latest_r, latest_nxt;
  pde_pkg::status_t        err_r, err_nxt;
  logic [7:0]              sym_r, sym_nxt;
  logic                    fin_r, fin_nxt;
  logic                    neg_r, neg_nxt;
  logic [pde_pkg::ITER_W-1:0] iter_r, iter_nxt;
  // shared working registers: accumulator / remainder, multiplicand / divisor,
  // multiplier / dividend-quotient
  pde_pkg::word_t          a_r, a_nxt;
  pde_pkg::word_t          b_r, b_nxt;
  pde_pkg::word_t          q_r, q_nxt;
  pde_pkg::word_t          res_r, res_nxt;

  logic                    out_valid_r, out_valid_nxt;
  pde_pkg::word_t          out_data_r, out_data_nxt;
  pde_pkg::status_t        out_user_r, out_user_nxt;

  // operand stack, two registered read ports for the top two entries
  pde_pkg::word_t          stack_mem [STACK_DEPTH];
  pde_pkg::word_t          top_r, next_r;
  logic                    wr_en;
  logic [AW-1:0]           wr_addr;
  pde_pkg::word_t          wr_data;
  logic [CW-1:0]           cnt_m1, cnt_m2;

  logic                    in_acc;
  logic                    dig_w;
  pde_pkg::op_t            op_w;
  pde_pkg::word_t          op_left, op_right;
  pde_pkg::word_t          mag_left, mag_right;

  // the shared adder/subtractor
  pde_pkg::word_t          alu_a, alu_b;
  logic                    alu_sub;
  logic [pde_pkg::WORD_W:0] alu_sum;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign dig_w      = pde_pkg::is_digit(in_tdata);
  assign op_w       = pde_pkg::decode_op(sym_r);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  assign cnt_m1 = count_r - ONE_C;
  assign cnt_m2 = count_r - TWO_C;

  // missing operands read as zero
  assign op_right  = (count_r >= ONE_C) ? top_r  : '0;
  assign op_left   = (count_r >= TWO_C) ? next_r : '0;
  assign mag_left  = op_left[31]  ? (pde_pkg::word_t'(0) - op_left)  : op_left;
  assign mag_right = op_right[31] ? (pde_pkg::word_t'(0) - op_right) : op_right;

  always_comb begin
    alu_a   = a_r;
    alu_b   = b_r;
    alu_sub = 1'b0;
    case (state_r)
      S_ADDSUB: begin
        alu_sub = (op_w == pde_pkg::OP_SUB);
      end
      S_MUL: begin
        alu_b = q_r[0] ? b_r : '0;
      end
      S_DIV: begin
        // remainder stays below divisor, so its top bit is always clear
        alu_a   = {a_r[30:0], q_r[31]};
        alu_sub = 1'b1;
      end
      S_NEG: begin
        alu_a   = '0;
        alu_b   = q_r;
        alu_sub = 1'b1;
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase
  end

  // bit 32 is the carry: on subtract it is set when alu_a >= alu_b
  assign alu_sum = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                 + {{pde_pkg::WORD_W{1'b0}}, alu_sub};

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    latest_nxt    = latest_r;
    err_nxt       = err_r;
    sym_nxt       = sym_r;
    fin_nxt       = fin_r;
    neg_nxt       = neg_r;
    iter_nxt      = iter_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    q_nxt         = q_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    wr_en         = 1'b0;
    wr_addr       = count_r[AW-1:0];
    wr_data       = res_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          sym_nxt = in_tdata;
          fin_nxt = in_tlast;
          if (dig_w) begin
            // digits push straight away
            if (count_r < DEPTH_C) begin
              wr_en     = 1'b1;
              wr_data   = pde_pkg::word_t'(in_tdata - pde_pkg::CH_ZERO);
              count_nxt = count_r + ONE_C;
            end else if (err_nxt == pde_pkg::ST_OK) begin
              err_nxt = pde_pkg::ST_OVERFLOW;
            end
            state_nxt = in_tlast ? S_EMIT : S_IDLE;
          end else begin
            state_nxt = S_OPER;
          end
        end
      end
      S_OPER: begin
        count_nxt = (count_r >= TWO_C) ? cnt_m2 : '0;
        if (count_r < TWO_C && err_nxt == pde_pkg::ST_OK) begin
          err_nxt = pde_pkg::ST_UNDERFLOW;
        end
        case (op_w)
          pde_pkg::OP_ADD, pde_pkg::OP_SUB: begin
            a_nxt     = op_left;
            b_nxt     = op_right;
            state_nxt = S_ADDSUB;
          end
          pde_pkg::OP_MUL: begin
            a_nxt     = '0;
            b_nxt     = op_left;
            q_nxt     = op_right;
            iter_nxt  = '0;
            state_nxt = S_MUL;
          end
          pde_pkg::OP_DIV: begin
            if (op_right == '0) begin
              if (err_nxt == pde_pkg::ST_OK) begin
                err_nxt = pde_pkg::ST_DIVZERO;
              end
              res_nxt   = '0;
              state_nxt = S_PUSH;
            end else begin
              a_nxt     = '0;
              b_nxt     = mag_right;
              q_nxt     = mag_left;
              neg_nxt   = op_left[31] ^ op_right[31];
              iter_nxt  = '0;
              state_nxt = S_DIV;
            end
          end
          default: begin
            res_nxt   = '1;
            state_nxt = S_PUSH;
          end
        endcase
      end
      S_ADDSUB: begin
        res_nxt   = alu_sum[31:0];
        state_nxt = S_PUSH;
      end
      S_MUL: begin
        a_nxt    = alu_sum[31:0];
        b_nxt    = {b_r[30:0], 1'b0};
        q_nxt    = {1'b0, q_r[31:1]};
        iter_nxt = iter_r + 1'b1;
        if (iter_r == '1) begin
          res_nxt   = alu_sum[31:0];
          state_nxt = S_PUSH;
        end
      end
      S_DIV: begin
        if (alu_sum[32]) begin
          a_nxt = alu_sum[31:0];
          q_nxt = {q_r[30:0], 1'b1};
        end else begin
          a_nxt = alu_a;
          q_nxt = {q_r[30:0], 1'b0};
        end
        iter_nxt = iter_r + 1'b1;
        if (iter_r == '1) begin
          state_nxt = S_NEG;
        end
      end
      S_NEG: begin
        res_nxt   = neg_r ? alu_sum[31:0] : q_r;
        state_nxt = S_PUSH;
      end
      S_PUSH: begin
        latest_nxt = res_r;
        if (count_r < DEPTH_C) begin
          wr_en     = 1'b1;
          wr_data   = res_r;
          count_nxt = count_r + ONE_C;
        end else if (err_nxt == pde_pkg::ST_OK) begin
          err_nxt = pde_pkg::ST_OVERFLOW;
        end
        state_nxt = fin_r ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        // wait for the output register to free up
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = latest_r;
          out_user_nxt  = err_r;
          count_nxt     = '0;
          latest_nxt    = '0;
          err_nxt       = pde_pkg::ST_OK;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= wr_data;
    end
    // top two entries, fetched while an operator beat is taken
    top_r  <= stack_mem[cnt_m1[AW-1:0]];
    next_r <= stack_mem[cnt_m2[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      latest_r    <= '0;
      err_r       <= pde_pkg::ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      latest_r    <= latest_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sym_r      <= sym_nxt;
    fin_r      <= fin_nxt;
    neg_r      <= neg_nxt;
    iter_r     <= iter_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    q_r        <= q_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  // stack fill never passes the depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("stack count beyond depth");

  // a digit with room grows the stack by one
  a_digit_push: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && dig_w && count_r < DEPTH_C) |=> (count_r == $past(count_r) + ONE_C))
    else $error("digit push lost");

  // restoring divide keeps the remainder below the divisor
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (a_r < b_r))
    else $error("divide remainder out of range");

  // handing over a result clears the expression state
  a_emit_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && (!out_valid_r || out_tready)) |=>
      (out_valid_r && count_r == '0 && latest_r == '0 && err_r == pde_pkg::ST_OK))
    else $error("emit did not clear state");

endmodule

[dv/postfix_digit_evaluator_test.sv]
module postfix_digit_evaluator_test;

  localparam int STACK_DEPTH = 32;
  localparam int TARGET_BEATS = 1050;
  // below this many queued beats both sides stop idling
  localparam int QUIET_TAIL = 150;
  // long receiver hold-off, started once enough beats have gone in
  localparam int LONG_HOLD = 300;
  localparam int HOLD_AFTER_BEATS = 500;
  // sender waits for every result at the expression that reaches this beat count
  localparam int DRAIN_AT_BEAT = 700;
  // settle time covers the slowest operator, a divide, plus the output hand-off
  localparam int SETTLE_CYCLES = 80;

  typedef struct {
    logic [7:0] symbol;
    logic       is_final;
    bit         wait_for_drain;
  } char_beat_t;

  typedef struct {
    pde_pkg::word_t   value;
    pde_pkg::status_t status;
  } eval_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] symbol
  logic        in_tlast = 1'b0;    // is_final
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;          // [31:0] value
  logic [1:0]  out_tuser;          // [1:0] status

  // expression characters still to send, and results still to come
  char_beat_t   char_queue[$];
  eval_result_t pending_results[$];

  // predictor state: operand stack, fill level, latest value, sticky status
  pde_pkg::word_t   eval_stack[STACK_DEPTH];
  int unsigned      eval_depth = 0;
  pde_pkg::word_t   eval_latest = '0;
  pde_pkg::status_t eval_status = pde_pkg::ST_OK;

  logic in_taken = 1'b0;
  int   send_gap = 0;
  int   stall_cnt = 0;
  int   hold_cnt = 0;
  bit   hold_done = 1'b0;
  int   beats_in = 0;
  int   results_seen = 0;
  int   exprs_built = 0;
  int   mismatches = 0;
  int   status_hits[4] = '{0, 0, 0, 0};

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  postfix_digit_evaluator #(
    .STACK_DEPTH(STACK_DEPTH)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // ---------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------

  // first error since the last clear wins
  function automatic void flag_status(pde_pkg::status_t code);
    if (eval_status == pde_pkg::ST_OK) eval_status = code;
  endfunction

  function automatic void eval_push(pde_pkg::word_t v);
    if (eval_depth >= STACK_DEPTH) begin
      flag_status(pde_pkg::ST_OVERFLOW);   // digit or result dropped on a full stack
    end else begin
      eval_stack[eval_depth] = v;
      eval_depth++;
    end
  endfunction

  // a missing operand reads as zero and marks underflow
  function automatic pde_pkg::word_t eval_pop();
    if (eval_depth == 0) begin
      flag_status(pde_pkg::ST_UNDERFLOW);
      return '0;
    end
    eval_depth--;
    return eval_stack[eval_depth];
  endfunction

  function automatic void eval_symbol(logic [7:0] sym, logic fin);
    pde_pkg::word_t right, left, r, ma, mb, q;
    logic  na, nb;
    if (sym >= pde_pkg::CH_ZERO && sym <= pde_pkg::CH_NINE) begin
      eval_push(pde_pkg::word_t'(sym - pde_pkg::CH_ZERO));
    end else begin
      right = eval_pop();
      left  = eval_pop();
      case (sym)
        pde_pkg::CH_STAR:  r = left * right;
        pde_pkg::CH_SLASH: begin
          // magnitudes, then sign fix; most negative over minus one wraps
          na = left[pde_pkg::WORD_W-1];
          nb = right[pde_pkg::WORD_W-1];
          ma = na ? pde_pkg::word_t'(0) - left : left;
          mb = nb ? pde_pkg::word_t'(0) - right : right;
          if (mb == '0) begin
            flag_status(pde_pkg::ST_DIVZERO);
            r = '0;
          end else begin
            q = ma / mb;
            r = (na != nb) ? pde_pkg::word_t'(0) - q : q;
          end
        end
        pde_pkg::CH_PLUS:  r = left + right;
        pde_pkg::CH_MINUS: r = left - right;
        default:           r = '1;
      endcase
      eval_push(r);
      eval_latest = r;
    end
    if (fin) begin
      pending_results.push_back('{eval_latest, eval_status});
      eval_depth  = 0;
      eval_latest = '0;
      eval_status = pde_pkg::ST_OK;
    end
  endfunction

  // ---------------------------------------------------------------------
  // stimulus building
  // ---------------------------------------------------------------------

  task automatic add_char(logic [7:0] sym, logic fin);
    char_queue.push_back('{sym, fin, 1'b0});
  endtask

  // whole expression from text, final flag on the last character
  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i], i == s.len() - 1);
    exprs_built++;
  endtask

  function automatic logic [7:0] pick_digit();
    return pde_pkg::CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] pick_operator();
    logic [7:0] sym;
    case ($urandom_range(0, 19))
      0:       begin
        // a stray non-digit that is none of the four operators
        sym = 8'($urandom_range(0, 255));
        if ((sym >= pde_pkg::CH_ZERO && sym <= pde_pkg::CH_NINE) ||
            sym == pde_pkg::CH_STAR || sym == pde_pkg::CH_SLASH ||
            sym == pde_pkg::CH_PLUS || sym == pde_pkg::CH_MINUS) sym = 8'hff;
      end
      1, 2, 3, 4, 5:     sym = pde_pkg::CH_STAR;
      6, 7, 8, 9, 10:    sym = pde_pkg::CH_SLASH;
      11, 12, 13, 14, 15: sym = pde_pkg::CH_PLUS;
      default:           sym = pde_pkg::CH_MINUS;
    endcase
    return sym;
  endfunction

  // balanced postfix expression with random digits and operators
  task automatic add_wellformed();
    logic [7:0] syms[$];
    int depth, len;
    depth = 0;
    len = $urandom_range(1, 12);
    for (int i = 0; i < len; i++) begin
      if (depth < 2 || $urandom_range(0, 1) == 0) begin
        syms.push_back(pick_digit());
        depth++;
      end else begin
        syms.push_back(pick_operator());
        depth--;
      end
    end
    while (depth > 1) begin
      syms.push_back(pick_operator());
      depth--;
    end
    foreach (syms[i]) add_char(syms[i], i == syms.size() - 1);
    exprs_built++;
  endtask

  // arbitrary bytes, mostly non-digits on a short stack
  task automatic add_noise();
    int len;
    len = $urandom_range(1, 6);
    for (int i = 0; i < len; i++) add_char(8'($urandom_range(0, 255)), i == len - 1);
    exprs_built++;
  endtask

  // deep stack, sometimes past full so later digits are dropped
  task automatic add_deep();
    int n;
    n = $urandom_range(28, 36);
    for (int i = 0; i < n; i++) add_char(pick_digit(), 1'b0);
    for (int i = 0; i < n - 1; i++) add_char(pick_operator(), i == n - 2);
    exprs_built++;
  endtask

  // two to the 31st by repeated doubling, then divided by minus one
  task automatic add_min_over_minus_one();
    add_char(pde_pkg::CH_ZERO + 8'd2, 1'b0);
    for (int i = 0; i < 30; i++) begin
      add_char(pde_pkg::CH_ZERO + 8'd2, 1'b0);
      add_char(pde_pkg::CH_STAR, 1'b0);
    end
    add_char(pde_pkg::CH_ZERO, 1'b0);
    add_char(pde_pkg::CH_ZERO + 8'd1, 1'b0);
    add_char(pde_pkg::CH_MINUS, 1'b0);
    add_char(pde_pkg::CH_SLASH, 1'b1);
    exprs_built++;
  endtask

  // ---------------------------------------------------------------------
  // sender: presents beats at the falling edge
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    char_beat_t nxt;
    logic       v;
    logic [7:0] d;
    logic       l;
    v = in_tvalid;
    d = in_tdata;
    l = in_tlast;
    // a beat on offer stays put until taken
    if (rst_n && (!in_tvalid || in_taken)) begin
      v = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (in_taken && char_queue.size() >= QUIET_TAIL &&
                   $urandom_range(0, 5) == 0) begin
        send_gap = $urandom_range(0, 6);   // this cycle is the first idle one
      end else if (char_queue.size() > 0 &&
                   !(char_queue[0].wait_for_drain && pending_results.size() > 0)) begin
        nxt = char_queue.pop_front();
        v = 1'b1;
        d = nxt.symbol;
        l = nxt.is_final;
      end
    end
    in_tvalid <= v;
    in_tdata  <= d;
    in_tlast  <= l;
  end

  // ---------------------------------------------------------------------
  // receiver: ready with random stalls and one long hold-off
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    logic r;
    r = 1'b1;
    if (!rst_n) begin
      r = 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      r = 1'b0;
    end else if (!hold_done && beats_in >= HOLD_AFTER_BEATS) begin
      // sender keeps offering, so the output register fills and input stalls
      hold_done = 1'b1;
      hold_cnt = LONG_HOLD - 1;
      r = 1'b0;
    end else if (stall_cnt > 0) begin
      stall_cnt--;
      r = 1'b0;
    end else if (char_queue.size() >= QUIET_TAIL && $urandom_range(0, 7) == 0) begin
      stall_cnt = $urandom_range(0, 6);
      r = 1'b0;
    end
    out_tready <= r;
  end

  // ---------------------------------------------------------------------
  // monitor: predicts on each input beat, checks each output beat
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    eval_result_t want;
    in_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      eval_symbol(in_tdata, in_tlast);
      beats_in++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat, value %0d status %0d", $time,
                 $signed(out_tdata), out_tuser);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata !== want.value) begin
          $display("%0t: value mismatch, expected %0d, actual %0d", $time,
                   $signed(want.value), $signed(out_tdata));
          mismatches++;
        end
        if (out_tuser !== want.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d", $time,
                   want.status, out_tuser);
          mismatches++;
        end
        status_hits[want.status]++;
      end
    end
  end

  // ---------------------------------------------------------------------
  // sequence: build stimulus, reset, drain, report
  // ---------------------------------------------------------------------
  initial begin
    int mark;
    // directed: lone digits, each operator, stray symbols, errors
    add_text("0");
    add_text("9");
    add_text("98*");
    add_text("39-4/");             // negative quotient truncates toward zero
    add_text("34+");
    add_char(pde_pkg::CH_ZERO + 8'd1, 1'b0);
    add_char(pde_pkg::CH_ZERO + 8'd2, 1'b0);
    add_char(8'hff, 1'b1);         // unknown operator gives minus one
    exprs_built++;
    add_text("+");                 // underflow on an empty stack
    add_text("50/+");              // divide by zero, then underflow is masked
    add_char(pde_pkg::CH_ZERO + 8'd1, 1'b0);
    add_char(8'h00, 1'b1);
    exprs_built++;

    // random: mostly well-formed expressions, some noise and deep stacks
    add_min_over_minus_one();
    while (char_queue.size() < TARGET_BEATS) begin
      mark = char_queue.size();
      case ($urandom_range(0, 39))
        0:                add_deep();
        1:                add_min_over_minus_one();
        2, 3, 4, 5, 6, 7: add_noise();
        default:          add_wellformed();
      endcase
      if (mark < DRAIN_AT_BEAT && char_queue.size() >= DRAIN_AT_BEAT)
        char_queue[mark].wait_for_drain = 1'b1;
    end
    add_deep();

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    while (char_queue.size() > 0 || in_tvalid) @(posedge clk);
    while (pending_results.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d beats in %0d expressions, %0d results checked", beats_in,
             exprs_built, results_seen);
    $display("status seen: ok %0d, underflow %0d, divide by zero %0d, overflow %0d",
             status_hits[pde_pkg::ST_OK], status_hits[pde_pkg::ST_UNDERFLOW],
             status_hits[pde_pkg::ST_DIVZERO], status_hits[pde_pkg::ST_OVERFLOW]);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #1000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
